>>> rtl/core/ebq_pkg.sv
package ebq_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int FW_W          = 11;
    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam int SUM_W         = 23;
    localparam int OUT_W         = 20;
    localparam int WGT_W         = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 24;

    typedef struct packed {
        logic ul;
        logic ur;
        logic ll;
        logic lr;
    } quad_t;

    typedef struct packed {
        logic step;
        logic count;
        logic last;
    } acc_ctrl_t;

    function automatic logic signed [WGT_W-1:0] quad_weight(quad_t q);
        logic [2:0] n;
        logic signed [WGT_W-1:0] w;
        n = {2'b00, q.ul} + {2'b00, q.ur} + {2'b00, q.ll} + {2'b00, q.lr};
        case (n)
            3'd1:    w = 3'sd1;
            3'd3:    w = -3'sd1;
            3'd2:    w = (q.ul == q.lr) ? -3'sd2 : 3'sd0;
            default: w = 3'sd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/ebq_ram.sv
module ebq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ebq_accum.sv
module ebq_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ebq_pkg::acc_ctrl_t                ctrl,
    input  ebq_pkg::quad_t                    quad,
    output logic signed [ebq_pkg::OUT_W-1:0]  euler
);
    import ebq_pkg::*;

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1 << (SUM_W-1));
    localparam logic signed [SUM_W-2:0] OUT_MAX = (SUM_W-1)'((1 << (OUT_W-1)) - 1);
    localparam logic signed [SUM_W-2:0] OUT_MIN = -(SUM_W-1)'(1 << (OUT_W-1));

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W:0]   sum_adj;
    logic signed [SUM_W-2:0] quot;
    logic signed [WGT_W-1:0] wgt;

    always_comb
    begin
        wgt      = quad_weight(quad);
        sum_wide = {sum_reg[SUM_W-1], sum_reg}
                 + {{(SUM_W+1-WGT_W){wgt[WGT_W-1]}}, wgt};
        if (!ctrl.count)
        begin
            sum_next = sum_reg;
        end
        else if (sum_wide > SUM_MAX)
        begin
            sum_next = SUM_MAX[SUM_W-1:0];
        end
        else if (sum_wide < SUM_MIN)
        begin
            sum_next = SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // truncate toward zero
    always_comb
    begin
        sum_adj = {sum_next[SUM_W-1], sum_next}
                + (sum_next[SUM_W-1] ? (SUM_W+1)'(3) : (SUM_W+1)'(0));
        quot = sum_adj[SUM_W:2];
        if (quot > OUT_MAX)
        begin
            euler = OUT_MAX[OUT_W-1:0];
        end
        else if (quot < OUT_MIN)
        begin
            euler = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            euler = quot[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.step)
        begin
            sum_reg <= ctrl.last ? '0 : sum_next;
        end
    end

endmodule

>>> rtl/core/euler_number_bit_quads.sv
// Euler number of a binary image (8-connectivity, bit-quad counting). Pixels enter in raster
// order on the slave stream, one beat per pixel, with tlast on the last pixel of the frame;
// the row width comes from the configuration register (0 acts as 1, values above MAX_WIDTH
// act as MAX_WIDTH). The block takes one pixel every clock: the previous row lives in a
// single-port-write, single-port-read line store that is read when a pixel is accepted and
// written when that pixel leaves the input register, with a bypass for back-to-back hits on
// the same column. A result beat carrying the Euler number is loaded into the output register
// when the frame's last pixel leaves the input register; input is held off only while that
// result waits in the output register and another end-of-frame pixel is already lined up
// behind it. The line store needs no clearing after reset.
module euler_number_bit_quads #(
    parameter int MAX_WIDTH = ebq_pkg::DEF_MAX_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ebq_pkg::FW_W-1:0]              cfg_wdata,   // frame_width
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ebq_pkg::IN_TDATA_W-1:0]        s_tdata,     // [0] pixel
    input  logic                                  s_tlast,     // frame_end
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ebq_pkg::OUT_TDATA_W-1:0]       m_tdata      // [19:0] euler value
);
    import ebq_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0]          width_reg;
    logic [WW-1:0]            eff_width;
    logic [CW-1:0]            col_reg;
    logic [CW-1:0]            col_next;
    logic [CW:0]              col_inc;
    logic                     first_row_reg;
    logic                     first_row_next;
    logic                     accept;
    logic                     wrap;

    logic                     s1_valid_reg;
    logic                     s1_pix_reg;
    logic                     s1_last_reg;
    logic                     s1_count_reg;
    logic [CW-1:0]            s1_col_reg;
    logic                     s1_go;
    logic                     fwd_reg;
    logic                     fwd_data_reg;
    logic                     ram_rdata;
    logic                     up;
    logic                     left_reg;
    logic                     ul_reg;

    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  euler_reg;
    logic signed [OUT_W-1:0]  euler;

    quad_t                    quad;
    acc_ctrl_t                acc_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= FW_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(width_reg);
        end
    end

    assign s1_go    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    // column and row tracking at the input side
    always_comb
    begin
        col_inc        = {1'b0, col_reg} + (CW+1)'(1);
        wrap           = 32'(col_inc) >= 32'(eff_width);
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                col_next       = '0;
                first_row_next = 1'b1;
            end
            else if (wrap)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_go && (s1_col_reg == col_reg);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= s_tdata[0];
            s1_last_reg  <= s_tlast;
            s1_count_reg <= (col_reg != '0) && !first_row_reg;
            s1_col_reg   <= col_reg;
            fwd_data_reg <= s1_pix_reg;
        end
    end

    ebq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign up = fwd_reg ? fwd_data_reg : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 1'b0;
            ul_reg   <= 1'b0;
        end
        else if (s1_go)
        begin
            left_reg <= s1_last_reg ? 1'b0 : s1_pix_reg;
            ul_reg   <= s1_last_reg ? 1'b0 : up;
        end
    end

    assign quad.ul = ul_reg;
    assign quad.ur = up;
    assign quad.ll = left_reg;
    assign quad.lr = s1_pix_reg;

    assign acc_ctrl.step  = s1_go;
    assign acc_ctrl.count = s1_count_reg;
    assign acc_ctrl.last  = s1_last_reg;

    ebq_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .quad  (quad),
        .euler (euler)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            euler_reg <= euler;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, euler_reg};

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(MAX_WIDTH))
        else $error("column count out of line store range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a waiting result");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (col_reg == '0 && first_row_reg))
        else $error("frame state not cleared after last beat");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> m_tvalid)
        else $error("end of frame beat produced no result");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ebq_pkg::*;

    localparam int ROW_MAX = DEF_MAX_WIDTH;
    localparam int RI_W    = $clog2(ROW_MAX);
    localparam int ACC_HI  = 2 ** (SUM_W - 1) - 1;
    localparam int ACC_LO  = -(2 ** (SUM_W - 1));
    localparam int EUL_HI  = 2 ** (OUT_W - 1) - 1;
    localparam int EUL_LO  = -(2 ** (OUT_W - 1));

    typedef enum int {PAT_NOISE, PAT_SPARSE, PAT_DENSE, PAT_CHECKER} pattern_t;

    typedef struct packed {
        logic                    do_cfg;
        logic [FW_W-1:0]         fw;
        logic                    pix;
        logic                    last;
        logic                    fixed;
        logic signed [OUT_W-1:0] val;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [FW_W-1:0]        cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic                    beat_fixed = 1'b0;
    logic signed [OUT_W-1:0] beat_fixed_val = '0;

    int   src_idle_pct = 37;
    int   snk_idle_pct = 65;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    // bit-quad tracker state
    logic                    row_mem [ROW_MAX];
    logic                    left_px;
    logic                    ul_px;
    logic                    top_row;
    int unsigned             col_pos;
    int                      quad_acc;
    logic [FW_W-1:0]         width_reg;
    logic signed [OUT_W-1:0] euler_due [$];

    int bad_count = 0;
    int pixels_seen = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int mode_pix = 0;
    int cur_fw = ROW_MAX;

    dir_row_t dir_tab [24];

    euler_number_bit_quads DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= !rx_hold && ($urandom_range(99) >= snk_idle_pct);
    end

    // long output stall, own cycle count
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("euler_number_bit_quads: mismatch");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic signed [OUT_W-1:0] want,
                                 input logic signed [OUT_W-1:0] got);
        if (bad_count < 10)
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
        bad_count++;
    endtask

    always @(posedge clk)
    begin : quad_tracker
        int unsigned             w;
        int unsigned             c;
        logic                    up;
        logic                    px;
        int                      n;
        int                      wgt;
        int                      e;
        logic signed [OUT_W-1:0] e_fld;
        logic signed [OUT_W-1:0] got;
        if (!rst_n)
        begin
            row_mem   = '{default: 1'b0};
            left_px   = 1'b0;
            ul_px     = 1'b0;
            col_pos   = 0;
            top_row   = 1'b1;
            quad_acc  = 0;
            width_reg = FW_RESET;
        end
        else
        begin
            if (cfg_we)
                width_reg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                pixels_seen++;
                px = s_tdata[0];
                w = 32'(width_reg);
                if (w < 1)
                    w = 1;
                if (w > ROW_MAX)
                    w = ROW_MAX;
                c = col_pos;
                if (c >= ROW_MAX)
                    c = 0;
                up = row_mem[c[RI_W-1:0]];
                if (c > 0 && !top_row)
                begin
                    n = int'(ul_px) + int'(up) + int'(left_px) + int'(px);
                    if (n == 1)
                        wgt = 1;
                    else if (n == 3)
                        wgt = -1;
                    else if (n == 2 && ul_px == px)
                        wgt = -2;
                    else
                        wgt = 0;
                    quad_acc = quad_acc + wgt;
                    if (quad_acc > ACC_HI)
                        quad_acc = ACC_HI;
                    if (quad_acc < ACC_LO)
                        quad_acc = ACC_LO;
                end
                row_mem[c[RI_W-1:0]] = px;
                ul_px      = up;
                left_px    = px;
                c++;
                if (c >= w)
                begin
                    c       = 0;
                    top_row = 1'b0;
                end
                col_pos = c;
                if (s_tlast)
                begin
                    e = quad_acc / 4;
                    if (e > EUL_HI)
                        e = EUL_HI;
                    if (e < EUL_LO)
                        e = EUL_LO;
                    e_fld = e[OUT_W-1:0];
                    euler_due.insert(euler_due.size(), beat_fixed ? beat_fixed_val : e_fld);
                    left_px  = 1'b0;
                    ul_px    = 1'b0;
                    col_pos  = 0;
                    top_row  = 1'b1;
                    quad_acc = 0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = m_tdata[OUT_W-1:0];
                if (euler_due.size() == 0)
                    flag_mismatch("unexpected result beat", 'x, got);
                else
                begin
                    e_fld = euler_due.pop_front();
                    if (got !== e_fld)
                        flag_mismatch("euler value", e_fld, got);
                end
            end
        end
    end

    task automatic send_beat(input logic pix, input logic last, input logic fixed,
                             input logic signed [OUT_W-1:0] val);
        s_tvalid       <= 1'b1;
        s_tdata        <= {{(IN_TDATA_W-1){1'b0}}, pix};
        s_tlast        <= last;
        beat_fixed     <= fixed;
        beat_fixed_val <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic await_drain();
        @(posedge clk);
        while (euler_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_width(input logic [FW_W-1:0] v);
        s_tvalid <= 1'b0;
        await_drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_fw = int'(v);
    endtask

    task automatic send_frame(input int eff, input int npix, input pattern_t kind);
        int   r;
        int   c;
        logic p;
        for (int i = 0; i < npix; i++)
        begin
            r = i / eff;
            c = i % eff;
            case (kind)
                PAT_NOISE:  p = 1'($urandom_range(1));
                PAT_SPARSE: p = ($urandom_range(9) == 0);
                PAT_DENSE:  p = ($urandom_range(9) != 0);
                default:    p = (((r + c) % 2) == 0) ^ ($urandom_range(15) == 0);
            endcase
            send_beat(p, i == npix - 1, 1'b0, '0);
        end
        frames_sent++;
        mode_pix += npix;
    endtask

    task automatic random_frame();
        int              r;
        int              eff;
        int              npix;
        logic [FW_W-1:0] v;
        if ($urandom_range(99) < 40)
        begin
            r = $urandom_range(99);
            if (r < 8)
                v = 11'd0;
            else if (r < 16)
                v = 11'd1;
            else if (r < 22)
                v = 11'd2047;
            else if (r < 28)
                v = 11'($urandom_range(1025, 2047));
            else if (r < 34)
                v = 11'd1024;
            else if (r < 40)
                v = 11'($urandom_range(65, 1023));
            else
                v = 11'($urandom_range(2, 12));
            write_width(v);
        end
        eff = (cur_fw == 0) ? 1 : ((cur_fw > ROW_MAX) ? ROW_MAX : cur_fw);
        if (eff > 64)
            npix = $urandom_range(1, 40);
        else
        begin
            npix = eff * $urandom_range(1, 7);
            if ($urandom_range(2) == 0)
                npix -= $urandom_range(0, eff - 1);
        end
        send_frame(eff, npix, pattern_t'($urandom_range(3)));
    endtask

    initial
    begin : stimulus
        int eff;
        dir_tab = '{
            '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, 20'sd0},  // lone pixel after reset
            '{1'b1, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},  // width 0 acts as 1
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, 20'sd0},
            '{1'b1, 11'd2,    1'b1, 1'b0, 1'b0, 20'sd0},  // three set
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b0, 1'b1, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},  // diagonal pair
            '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b1, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},  // checkerboard, four diagonals
            '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, 20'sd0},
            '{1'b0, 11'd0,    1'b0, 1'b1, 1'b1, -20'sd2},
            '{1'b1, 11'd2047, 1'b0, 1'b0, 1'b0, 20'sd0},  // above max acts as max
            '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, 20'sd0}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].do_cfg)
                write_width(dir_tab[i].fw);
            send_beat(dir_tab[i].pix, dir_tab[i].last, dir_tab[i].fixed, dir_tab[i].val);
        end
        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle_pct = (mode == 0) ? 37 : ((mode == 1) ? 65 : 0);
            snk_idle_pct = (mode == 0) ? 65 : ((mode == 1) ? 37 : 0);
            mode_pix = 0;
            if (mode == 1)
            begin
                // back-to-back one-pixel frames against a stalled output
                hold_go = 1'b1;
                eff = (cur_fw == 0) ? 1 : ((cur_fw > ROW_MAX) ? ROW_MAX : cur_fw);
                repeat (30) send_frame(eff, 1, PAT_NOISE);
            end
            if (mode == 2)
            begin
                // full-width rows, width above max
                write_width(11'd2047);
                send_frame(ROW_MAX, ROW_MAX + 7, PAT_NOISE);
            end
            while (mode_pix < 150)
                random_frame();
        end
        s_tvalid <= 1'b0;
        await_drain();
        repeat (20) @(posedge clk);
        $display("covered %0d pixels in %0d frames, %0d results checked, widths 0 to 2047",
                 pixels_seen, frames_sent + 6, results_seen);
        $display("idle mixes 37/65, 65/37 and none, plus one long output stall");
        if (bad_count == 0)
            $display("euler_number_bit_quads: match");
        else
            $display("euler_number_bit_quads: mismatch");
        $finish;
    end

endmodule
